[design/r2k_pkg.sv]
// r2k_pkg: shared types, constants and the romaji key rom for romaji_to_kana_stream
// no dependencies

package r2k_pkg;

  localparam int MaxPattern = 4;
  localparam int RomEntries = 215;
  localparam int RomIdxW = 8;
  localparam int QueueDepth = 4;

  // one pending job for the back end
  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_CHAR,
    JOB_FLUSH
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] ch;
  } job_t;

  // back end control states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEARCH,
    ST_EMIT,
    ST_TERM
  } st_t;

  // a rom entry: key (up to four chars, first char in low byte), length, two code points
  typedef struct packed {
    logic [31:0] key;
    logic [2:0]  len;
    logic [15:0] k0;
    logic [15:0] k1;
  } rom_entry_t;

  function automatic rom_entry_t mk(input string s, input logic [15:0] a,
                                    input logic [15:0] b);
    rom_entry_t e;
    e.key = '0;
    e.len = 3'(s.len());
    for (int i = 0; i < 4; i++) begin
      if (i < s.len()) e.key[i*8 +: 8] = s[i];
    end
    e.k0 = a;
    e.k1 = b;
    return e;
  endfunction

  function automatic rom_entry_t rom_read(input logic [RomIdxW-1:0] idx);
    rom_entry_t e;
    e = '0;
    case (idx)
      0: e = mk("wa",16'h308F,0); 1: e = mk("wi",16'h3046,16'h3043);
      2: e = mk("we",16'h3046,16'h3047); 3: e = mk("wo",16'h3092,0);
      4: e = mk("wha",16'h3046,16'h3041); 5: e = mk("whi",16'h3046,16'h3043);
      6: e = mk("whe",16'h3046,16'h3047); 7: e = mk("who",16'h3046,16'h3049);
      8: e = mk("a",16'h3042,0); 9: e = mk("i",16'h3044,0); 10: e = mk("u",16'h3046,0);
      11: e = mk("e",16'h3048,0); 12: e = mk("o",16'h304A,0);
      13: e = mk("wu",16'h3046,0); 14: e = mk("whu",16'h3046,0);
      15: e = mk("tha",16'h3066,16'h3083); 16: e = mk("thi",16'h3066,16'h3043);
      17: e = mk("thu",16'h3066,16'h3085); 18: e = mk("the",16'h3066,16'h3047);
      19: e = mk("tho",16'h3066,16'h3087);
      20: e = mk("va",16'h3094,16'h3041); 21: e = mk("vi",16'h3094,16'h3043);
      22: e = mk("ve",16'h3094,16'h3047); 23: e = mk("vo",16'h3094,16'h3049);
      24: e = mk("vu",16'h3094,0);
      25: e = mk("ja",16'h3058,16'h3083); 26: e = mk("ju",16'h3058,16'h3085);
      27: e = mk("je",16'h3058,16'h3047); 28: e = mk("jo",16'h3058,16'h3087);
      29: e = mk("ji",16'h3058,0);
      30: e = mk("dha",16'h3067,16'h3083); 31: e = mk("dhi",16'h3067,16'h3043);
      32: e = mk("dhu",16'h3067,16'h3085); 33: e = mk("dhe",16'h3067,16'h3047);
      34: e = mk("dho",16'h3067,16'h3087);
      35: e = mk("jya",16'h3058,16'h3083); 36: e = mk("jyi",16'h3058,16'h3043);
      37: e = mk("jyu",16'h3058,16'h3085); 38: e = mk("jye",16'h3058,16'h3047);
      39: e = mk("jyo",16'h3058,16'h3087);
      40: e = mk("kya",16'h304D,16'h3083); 41: e = mk("kyi",16'h304D,16'h3043);
      42: e = mk("kyu",16'h304D,16'h3085); 43: e = mk("kye",16'h304D,16'h3047);
      44: e = mk("kyo",16'h304D,16'h3087);
      45: e = mk("sha",16'h3057,16'h3083); 46: e = mk("shu",16'h3057,16'h3085);
      47: e = mk("she",16'h3057,16'h3047); 48: e = mk("sho",16'h3057,16'h3087);
      49: e = mk("sya",16'h3057,16'h3083); 50: e = mk("syi",16'h3057,16'h3043);
      51: e = mk("syu",16'h3057,16'h3085); 52: e = mk("sye",16'h3057,16'h3047);
      53: e = mk("syo",16'h3057,16'h3087);
      54: e = mk("shi",16'h3057,0);
      55: e = mk("cha",16'h3061,16'h3083); 56: e = mk("chi",16'h3061,0);
      57: e = mk("chu",16'h3061,16'h3085); 58: e = mk("che",16'h3061,16'h3047);
      59: e = mk("cho",16'h3061,16'h3087);
      60: e = mk("tya",16'h3061,16'h3083); 61: e = mk("tyi",16'h3061,16'h3043);
      62: e = mk("tyu",16'h3061,16'h3085); 63: e = mk("tye",16'h3061,16'h3047);
      64: e = mk("tyo",16'h3061,16'h3087);
      65: e = mk("cya",16'h3061,16'h3083); 66: e = mk("cyi",16'h3061,16'h3043);
      67: e = mk("cyu",16'h3061,16'h3085); 68: e = mk("cye",16'h3061,16'h3047);
      69: e = mk("cyo",16'h3061,16'h3087);
      70: e = mk("tsu",16'h3064,0);
      71: e = mk("ta",16'h305F,0); 72: e = mk("ti",16'h3061,0); 73: e = mk("tu",16'h3064,0);
      74: e = mk("te",16'h3066,0); 75: e = mk("to",16'h3068,0);
      76: e = mk("nya",16'h306B,16'h3083); 77: e = mk("nyi",16'h306B,16'h3043);
      78: e = mk("nyu",16'h306B,16'h3085); 79: e = mk("nye",16'h306B,16'h3047);
      80: e = mk("nyo",16'h306B,16'h3087);
      81: e = mk("hya",16'h3072,16'h3083); 82: e = mk("hyi",16'h3072,16'h3043);
      83: e = mk("hyu",16'h3072,16'h3085); 84: e = mk("hye",16'h3072,16'h3047);
      85: e = mk("hyo",16'h3072,16'h3087);
      86: e = mk("fa",16'h3075,16'h3041); 87: e = mk("fi",16'h3075,16'h3043);
      88: e = mk("fe",16'h3075,16'h3047); 89: e = mk("fo",16'h3075,16'h3049);
      90: e = mk("fu",16'h3075,0);
      91: e = mk("mya",16'h307F,16'h3083); 92: e = mk("myi",16'h307F,16'h3043);
      93: e = mk("myu",16'h307F,16'h3085); 94: e = mk("mye",16'h307F,16'h3047);
      95: e = mk("myo",16'h307F,16'h3087);
      96: e = mk("rya",16'h308A,16'h3083); 97: e = mk("ryi",16'h308A,16'h3043);
      98: e = mk("ryu",16'h308A,16'h3085); 99: e = mk("rye",16'h308A,16'h3047);
      100: e = mk("ryo",16'h308A,16'h3087);
      101: e = mk("gya",16'h304E,16'h3083); 102: e = mk("gyi",16'h304E,16'h3043);
      103: e = mk("gyu",16'h304E,16'h3085); 104: e = mk("gye",16'h304E,16'h3047);
      105: e = mk("gyo",16'h304E,16'h3087);
      106: e = mk("gwa",16'h3050,16'h3041); 107: e = mk("gwi",16'h3050,16'h3043);
      108: e = mk("gwu",16'h3050,16'h3045); 109: e = mk("gwe",16'h3050,16'h3047);
      110: e = mk("gwo",16'h3050,16'h3049);
      111: e = mk("dya",16'h3062,16'h3083); 112: e = mk("dyi",16'h3062,16'h3043);
      113: e = mk("dyu",16'h3062,16'h3085); 114: e = mk("dye",16'h3062,16'h3047);
      115: e = mk("dyo",16'h3062,16'h3087);
      116: e = mk("bya",16'h3073,16'h3083); 117: e = mk("byi",16'h3073,16'h3043);
      118: e = mk("byu",16'h3073,16'h3085); 119: e = mk("bye",16'h3073,16'h3047);
      120: e = mk("byo",16'h3073,16'h3087);
      121: e = mk("pya",16'h3074,16'h3083); 122: e = mk("pyi",16'h3074,16'h3043);
      123: e = mk("pyu",16'h3074,16'h3085); 124: e = mk("pye",16'h3074,16'h3047);
      125: e = mk("pyo",16'h3074,16'h3087);
      126: e = mk("ka",16'h304B,0); 127: e = mk("ki",16'h304D,0); 128: e = mk("ku",16'h304F,0);
      129: e = mk("ke",16'h3051,0); 130: e = mk("ko",16'h3053,0);
      131: e = mk("sa",16'h3055,0); 132: e = mk("si",16'h3057,0); 133: e = mk("su",16'h3059,0);
      134: e = mk("se",16'h305B,0); 135: e = mk("so",16'h305D,0);
      136: e = mk("na",16'h306A,0); 137: e = mk("ni",16'h306B,0); 138: e = mk("nu",16'h306C,0);
      139: e = mk("ne",16'h306D,0); 140: e = mk("no",16'h306E,0);
      141: e = mk("ha",16'h306F,0); 142: e = mk("hi",16'h3072,0); 143: e = mk("hu",16'h3075,0);
      144: e = mk("he",16'h3078,0); 145: e = mk("ho",16'h307B,0);
      146: e = mk("ma",16'h307E,0); 147: e = mk("mi",16'h307F,0); 148: e = mk("mu",16'h3080,0);
      149: e = mk("me",16'h3081,0); 150: e = mk("mo",16'h3082,0);
      151: e = mk("ya",16'h3084,0); 152: e = mk("yi",16'h3090,0); 153: e = mk("yu",16'h3086,0);
      154: e = mk("ye",16'h3091,0); 155: e = mk("yo",16'h3088,0);
      156: e = mk("ra",16'h3089,0); 157: e = mk("ri",16'h308A,0); 158: e = mk("ru",16'h308B,0);
      159: e = mk("re",16'h308C,0); 160: e = mk("ro",16'h308D,0);
      161: e = mk("ga",16'h304C,0); 162: e = mk("gi",16'h304E,0); 163: e = mk("gu",16'h3050,0);
      164: e = mk("ge",16'h3052,0); 165: e = mk("go",16'h3054,0);
      166: e = mk("za",16'h3056,0); 167: e = mk("zi",16'h3058,0); 168: e = mk("zu",16'h305A,0);
      169: e = mk("ze",16'h305C,0); 170: e = mk("zo",16'h305E,0);
      171: e = mk("da",16'h3060,0); 172: e = mk("di",16'h3062,0); 173: e = mk("du",16'h3065,0);
      174: e = mk("de",16'h3067,0); 175: e = mk("do",16'h3069,0);
      176: e = mk("ba",16'h3070,0); 177: e = mk("bi",16'h3073,0); 178: e = mk("bu",16'h3076,0);
      179: e = mk("be",16'h3079,0); 180: e = mk("bo",16'h307C,0);
      181: e = mk("pa",16'h3071,0); 182: e = mk("pi",16'h3074,0); 183: e = mk("pu",16'h3077,0);
      184: e = mk("pe",16'h307A,0); 185: e = mk("po",16'h307D,0);
      186: e = mk("ca",16'h304B,0); 187: e = mk("ci",16'h3057,0); 188: e = mk("cu",16'h304F,0);
      189: e = mk("ce",16'h305B,0); 190: e = mk("co",16'h3053,0);
      191: e = mk("n",16'h3093,0); 192: e = mk("-",16'h30FC,0);
      193: e = mk("ltu",16'h3063,0); 194: e = mk("ltsu",16'h3063,0);
      195: e = mk("xtu",16'h3063,0); 196: e = mk("xtsu",16'h3063,0);
      197: e = mk("lya",16'h3083,0); 198: e = mk("lyu",16'h3085,0);
      199: e = mk("lyo",16'h3087,0);
      200: e = mk("la",16'h3041,0); 201: e = mk("li",16'h3043,0); 202: e = mk("lu",16'h3045,0);
      203: e = mk("le",16'h3047,0); 204: e = mk("lo",16'h3049,0);
      205: e = mk("xya",16'h3083,0); 206: e = mk("xyu",16'h3085,0);
      207: e = mk("xyo",16'h3087,0);
      208: e = mk("xa",16'h3041,0); 209: e = mk("xi",16'h3043,0); 210: e = mk("xu",16'h3045,0);
      211: e = mk("xe",16'h3047,0); 212: e = mk("xo",16'h3049,0);
      213: e = mk("lwa",16'h308E,0); 214: e = mk("xwa",16'h308E,0);
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic logic is_consonant(input logic [7:0] c);
    logic r;
    r = 1'b0;
    case (c)
      "k", "s", "t", "n", "h", "m", "y", "r", "w", "z", "j", "p", "b", "c", "g", "f",
      "x": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[design/r2k_front.sv]
// r2k_front: accepts input beats, turns zero characters into no-op jobs, queues jobs
// depends on r2k_pkg

module r2k_front (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        word_end,
  output logic        job_valid,
  input  logic        job_ready,
  output r2k_pkg::job_t job
);
  import r2k_pkg::*;

  job_t       q [QueueDepth];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] fill;
  logic       push;
  logic       pop;
  job_t       in_job;

  // a zero char without word end still becomes a no-op job so run_last timing is trivial
  always_comb begin
    in_job.ch = in_char;
    if (word_end) in_job.kind = JOB_FLUSH;
    else if (in_char == 8'd0) in_job.kind = JOB_NONE;
    else in_job.kind = JOB_CHAR;
  end

  assign in_ready  = (fill != 3'(QueueDepth));
  assign push      = in_valid && in_ready;
  assign job_valid = (fill != 3'd0);
  assign pop       = job_valid && job_ready;
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + 3'(push) - 3'(pop);
    end
  end

endmodule

[design/r2k_back.sv]
// r2k_back: lookahead window, rom search and utf-8 byte emission
// depends on r2k_pkg

module r2k_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  r2k_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          run_last
);
  import r2k_pkg::*;

  st_t        state;
  st_t        state_next;
  logic [7:0] win [MaxPattern];
  logic [2:0] cnt;
  logic       flushing;
  logic [RomIdxW-1:0] idx;
  logic [15:0] cp0;
  logic [15:0] cp1;
  logic [2:0]  nbytes;
  logic [2:0]  bsel;
  logic [2:0]  used;
  logic        more;
  logic        out_full;
  logic        emit_go;
  logic        out_load;

  rom_entry_t  ent;
  logic        ent_hit;
  logic        dbl;
  logic        nrule;
  logic [2:0]  nused;
  logic        need_resolve;
  logic [15:0] cur_cp;
  logic [5:0]  bidx;
  logic [7:0]  cur_byte;

  assign ent = rom_read(idx);

  always_comb begin
    ent_hit = (ent.len != 3'd0) && (ent.len <= cnt);
    for (int j = 0; j < MaxPattern; j++) begin
      if (3'(j) < ent.len && ent.key[j*8 +: 8] != win[j]) ent_hit = 1'b0;
    end
  end

  assign dbl   = (cnt >= 3'd2) && is_consonant(win[0]) && (win[1] == win[0]);
  assign nrule = (win[0] == "n") && ((cnt == 3'd1) || (win[1] == 8'h0A) ||
                 (win[1] == "-") || (win[1] == 8'h27));
  assign nused = ((cnt >= 3'd2) && (win[1] == 8'h27)) ? 3'd2 : 3'd1;
  assign need_resolve = flushing ? (cnt != 3'd0) : (cnt >= 3'(MaxPattern));

  // byte select: 0..2 from cp0, 3..5 from cp1
  assign cur_cp = (bsel < 3'd3) ? cp0 : cp1;
  always_comb begin
    bidx = (bsel < 3'd3) ? 6'(bsel) : 6'(bsel - 3'd3);
    case (bidx)
      6'd0:    cur_byte = {4'hE, cur_cp[15:12]};
      6'd1:    cur_byte = {2'b10, cur_cp[11:6]};
      default: cur_byte = {2'b10, cur_cp[5:0]};
    endcase
  end

  // a byte stays hidden until we know whether it is the last one of its run
  assign out_valid = out_full && (run_last || (state == ST_EMIT && bsel != nbytes) ||
                     state == ST_TERM);
  assign emit_go   = !out_full || (out_valid && out_ready);
  assign out_load  = emit_go && ((state == ST_EMIT && bsel != nbytes) || state == ST_TERM);
  assign job_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (job_valid) begin
        if (job.kind == JOB_NONE) state_next = ST_IDLE;
        else state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!need_resolve) state_next = flushing ? ST_TERM : ST_IDLE;
        else if (dbl || nrule) state_next = ST_EMIT;
        else state_next = ST_SEARCH;
      end
      ST_SEARCH: if (ent_hit || idx == RomIdxW'(RomEntries - 1)) state_next = ST_EMIT;
      ST_EMIT:   if (bsel == nbytes || emit_go) begin
        if (bsel == nbytes || bsel + 3'd1 == nbytes) state_next = ST_DECIDE;
      end
      ST_TERM:   if (emit_go) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // output register with last flag fixed up when the run ends with no more bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      flushing <= 1'b0;
      out_full <= 1'b0;
      run_last <= 1'b0;
      more     <= 1'b0;
      for (int j = 0; j < MaxPattern; j++) win[j] <= '0;
    end else begin
      state <= state_next;
      if (out_load) out_full <= 1'b1;
      else if (out_valid && out_ready) out_full <= 1'b0;
      unique case (state)
        ST_IDLE: if (job_valid) begin
          more <= 1'b0;
          if (job.kind == JOB_FLUSH) flushing <= 1'b1;
          else if (job.kind == JOB_CHAR) begin
            flushing <= 1'b0;
            if (cnt < 3'(MaxPattern)) begin
              win[cnt[1:0]] <= job.ch;
              cnt <= cnt + 3'd1;
            end
          end
        end
        ST_DECIDE: begin
          idx  <= '0;
          bsel <= '0;
          if (!need_resolve) begin
            // mark the last emitted byte as run end
            if (!flushing && more) begin
              run_last <= 1'b1;
            end
          end else if (dbl) begin
            cp0 <= 16'h3063; cp1 <= 16'h0000; nbytes <= 3'd3; used <= 3'd1;
          end else if (nrule) begin
            cp0 <= 16'h3093; cp1 <= 16'h0000; nbytes <= 3'd3; used <= nused;
          end
        end
        ST_SEARCH: begin
          if (ent_hit) begin
            cp0 <= ent.k0;
            cp1 <= ent.k1;
            nbytes <= (ent.k1 != 16'd0) ? 3'd6 : 3'd3;
            used <= ent.len;
          end else if (idx == RomIdxW'(RomEntries - 1)) begin
            nbytes <= 3'd0;
            used <= 3'd1;
          end
          idx <= idx + 1'b1;
        end
        ST_EMIT: begin
          if (bsel != nbytes && emit_go) begin
            out_byte <= cur_byte;
            run_last <= 1'b0;
            more     <= 1'b1;
            bsel     <= bsel + 3'd1;
          end
          if (state_next == ST_DECIDE) begin
            for (int j = 0; j < MaxPattern; j++) begin
              win[j] <= (j + int'(used) < MaxPattern) ? win[2'(j + int'(used))] : 8'd0;
            end
            cnt <= cnt - used;
          end
        end
        ST_TERM: if (emit_go) begin
          out_byte <= 8'd0;
          run_last <= 1'b1;
          flushing <= 1'b0;
          cnt      <= '0;
          for (int j = 0; j < MaxPattern; j++) win[j] <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

[design/romaji_to_kana_stream.sv]
// romaji_to_kana_stream: top level, front end queue plus back end transliterator
// depends on r2k_pkg, r2k_front, r2k_back
//
// channels: in_valid/in_ready carry in_char and word_end, out_valid/out_ready
//   carry out_byte and run_last; run_last marks the last byte caused by a beat
// a character beat appends to a four-char lookahead window; once full, the
//   head is resolved (doubled consonant, final n, or first rom key match,
//   else dropped) and its kana go out as utf-8 bytes; word_end flushes,
//   then a zero byte; the front queue holds four beats
// back end steps
//   a beat that resolves nothing passes the take and decide steps; each
//   resolve adds a decide step, a search of one rom entry per cycle up to
//   the hit (all 215 when nothing matches, none for a doubled consonant or
//   final n) and one byte per cycle while the output is not stalled
//   a byte is shown once the next byte or the end of its run is known, so
//   the last byte of a beat waits for the next decide step
// reset: rst empties the queue and window and drops any pending output
// stall: when out_ready is low the output register holds and the back end
//   waits; the front keeps taking beats until its queue is full

module romaji_to_kana_stream (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       word_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last
);
  import r2k_pkg::*;

  job_t job;
  logic job_valid;
  logic job_ready;

  r2k_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_char, .word_end,
    .job_valid, .job_ready, .job
  );

  r2k_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .out_byte, .run_last
  );

endmodule
